// File: design/spc_pkg.sv
// Shared types, constants and tables for the stereo peak compressor.
package spc_pkg;

   // Sample width of the input and output fields.
   localparam int SAMPLE_BITS = 24;

   // Configuration port geometry.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, in the order of the register map.
   localparam logic [2:0] REG_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_RATIO      = 3'd1;
   localparam logic [2:0] REG_ATTACK     = 3'd2;
   localparam logic [2:0] REG_RELEASE    = 3'd3;
   localparam logic [2:0] REG_ENV_COEF   = 3'd4;
   localparam logic [2:0] REG_VOLUME     = 3'd5;
   localparam logic [2:0] REG_ACCUMULATE = 3'd6;

   // Register reset values.
   localparam logic [23:0] THRESHOLD_RESET = 24'd16584703;
   localparam logic [16:0] RATIO_RESET     = 17'd65536;
   localparam logic [23:0] ATTACK_RESET    = 24'd16776000;
   localparam logic [31:0] RELEASE_RESET   = 32'd16777400;
   localparam logic [23:0] ENV_COEF_RESET  = 24'd17410;
   localparam logic [31:0] VOLUME_RESET    = 32'd65536;

   // Gain limits in Q1.24 and the slope that means no compression.
   localparam logic [24:0] GAIN_UNITY  = 25'h1000000;
   localparam logic [24:0] GAIN_MAX    = 25'h1FFFFFF;
   localparam logic [16:0] SLOPE_UNITY = 17'h10000;

   // Step counts of the iterative units.
   localparam int SQRT_STEPS = 32;
   localparam int NORM_STEPS = 5;
   localparam int LOG_STEPS  = 16;
   localparam int EXP_STEPS  = 16;

   // Input and result beats.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic signed [SAMPLE_BITS-1:0] left_prior;
      logic signed [SAMPLE_BITS-1:0] right_prior;
   } spc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } spc_rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [23:0] threshold;
      logic [16:0] ratio_slope;
      logic [23:0] attack_coef;
      logic [31:0] release_mult;
      logic [23:0] env_coef;
      logic [31:0] volume;
      logic        accumulate;
   } spc_cfg_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_ENV_A,
      OP_ENV_B,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_LOG_INIT,
      OP_NORM_STEP,
      OP_LOG_MANT,
      OP_LOG_SQ,
      OP_LOG_SAVE,
      OP_SCALE,
      OP_EXP_INIT,
      OP_EXP_STEP,
      OP_TARGET,
      OP_GAIN,
      OP_OUT_MAG,
      OP_OUT_VOL,
      OP_OUT_SUM,
      OP_EMIT
   } spc_op_type;

   typedef struct packed {
      spc_op_type op;
      logic [4:0] idx;
      logic       sel;   // log operand: 0 level, 1 threshold
      logic       chan;  // output channel: 0 left, 1 right
   } spc_cmd_type;

   typedef struct packed {
      logic take_log;
   } spc_status_type;

   typedef logic [EXP_STEPS-1:0][31:0] spc_root_tab_type;

   // Repeated square roots of two in Q1.30, entry k-1 holds 2^(1/2^k).
   function automatic spc_root_tab_type spc_exp_table();
      spc_root_tab_type tab;
      logic [63:0] c;
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      c = 64'd1 << 31;
      for (int k = 0; k < EXP_STEPS; k++) begin
         x = c << 30;
         r = '0;
         b = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         c = r;
         tab[k] = c[31:0];
      end
      return tab;
   endfunction

endpackage

// File: design/stereo_peak_compressor.sv
// Stereo peak compressor: top level joining registers, controller and datapath.
//
// One beat on the req channel carries a left/right sample pair and the prior
// output pair; one beat on the rsp channel returns the processed pair. A beat
// moves at a clock edge where valid is high and stall is low.
// The block works on one pair at a time. Each pair passes the 32-step square
// root of the envelope; when the level is above threshold and the slope is
// not unity, it also takes two 16-step log2 passes and a 16-step exp2 pass
// to compute the target gain, all sharing one multiplier. A new input beat is
// taken as soon as the previous pair has moved to the output register, even
// while that result is still stalled. If the receiver stalls, the finished
// pair waits in the output register and the next pair waits at its last step
// until the register frees. Synchronous reset clears the envelope, sets the
// gain to unity, loads the register defaults and empties both channels. The
// user must see that registers are written through the APB-style port only
// while the block is idle; the block itself does not enforce this.
module stereo_peak_compressor
   import spc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  spc_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output spc_rsp_type              rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   spc_cfg_type    cfg;
   spc_cmd_type    cmd;
   spc_status_type status;

   // Configuration registers.
   spc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   spc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: design/spc_csr.sv
// Configuration registers behind the APB-style port.
module spc_csr
   import spc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output spc_cfg_type              cfg
);

   spc_cfg_type cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THRESHOLD_RESET;
         cfg_ff.ratio_slope  <= RATIO_RESET;
         cfg_ff.attack_coef  <= ATTACK_RESET;
         cfg_ff.release_mult <= RELEASE_RESET;
         cfg_ff.env_coef     <= ENV_COEF_RESET;
         cfg_ff.volume       <= VOLUME_RESET;
         cfg_ff.accumulate   <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_THRESHOLD:  cfg_ff.threshold    <= csr_pwdata[23:0];
            REG_RATIO:      cfg_ff.ratio_slope  <= csr_pwdata[16:0];
            REG_ATTACK:     cfg_ff.attack_coef  <= csr_pwdata[23:0];
            REG_RELEASE:    cfg_ff.release_mult <= csr_pwdata[31:0];
            REG_ENV_COEF:   cfg_ff.env_coef     <= csr_pwdata[23:0];
            REG_VOLUME:     cfg_ff.volume       <= csr_pwdata[31:0];
            REG_ACCUMULATE: cfg_ff.accumulate   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         REG_THRESHOLD:  csr_prdata = 32'(cfg_ff.threshold);
         REG_RATIO:      csr_prdata = 32'(cfg_ff.ratio_slope);
         REG_ATTACK:     csr_prdata = 32'(cfg_ff.attack_coef);
         REG_RELEASE:    csr_prdata = cfg_ff.release_mult;
         REG_ENV_COEF:   csr_prdata = 32'(cfg_ff.env_coef);
         REG_VOLUME:     csr_prdata = cfg_ff.volume;
         REG_ACCUMULATE: csr_prdata = 32'(cfg_ff.accumulate);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// File: design/spc_ctrl.sv
// Controller that sequences one sample pair through the shared datapath.
module spc_ctrl
   import spc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  spc_status_type status,
   output spc_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_ENV_A,
      S_ENV_B,
      S_SQRT_INIT,
      S_SQRT,
      S_CHECK,
      S_LOG_INIT,
      S_NORM,
      S_LOG_MANT,
      S_LOG_SQ,
      S_LOG_SAVE,
      S_SCALE,
      S_EXP_INIT,
      S_EXP,
      S_TARGET,
      S_GAIN,
      S_OUT_MAG,
      S_OUT_VOL,
      S_OUT_SUM,
      S_EMIT
   } state_type;

   state_type  state_ff;
   logic [4:0] cnt_ff;
   logic       sel_ff;
   logic       chan_ff;
   logic       req_stall_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Command decode from the current state.
   always_comb begin
      cmd.idx  = cnt_ff;
      cmd.sel  = sel_ff;
      cmd.chan = chan_ff;
      case (state_ff)
         S_IDLE:      cmd.op = req_valid ? OP_LOAD : OP_NOP;
         S_ENV_A:     cmd.op = OP_ENV_A;
         S_ENV_B:     cmd.op = OP_ENV_B;
         S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
         S_SQRT:      cmd.op = OP_SQRT_STEP;
         S_LOG_INIT:  cmd.op = OP_LOG_INIT;
         S_NORM:      cmd.op = OP_NORM_STEP;
         S_LOG_MANT:  cmd.op = OP_LOG_MANT;
         S_LOG_SQ:    cmd.op = OP_LOG_SQ;
         S_LOG_SAVE:  cmd.op = OP_LOG_SAVE;
         S_SCALE:     cmd.op = OP_SCALE;
         S_EXP_INIT:  cmd.op = OP_EXP_INIT;
         S_EXP:       cmd.op = OP_EXP_STEP;
         S_TARGET:    cmd.op = OP_TARGET;
         S_GAIN:      cmd.op = OP_GAIN;
         S_OUT_MAG:   cmd.op = OP_OUT_MAG;
         S_OUT_VOL:   cmd.op = OP_OUT_VOL;
         S_OUT_SUM:   cmd.op = OP_OUT_SUM;
         S_EMIT:      cmd.op = out_free ? OP_EMIT : OP_NOP;
         default:     cmd.op = OP_NOP;
      endcase
   end

   // State, step counter and handshake registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= 1'b0;
         chan_ff      <= 1'b0;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result beat is raised when the pair leaves, else a taken beat drops.
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_stall_ff <= 1'b1;
                  state_ff     <= S_ENV_A;
               end
            end
            S_ENV_A: state_ff <= S_ENV_B;
            S_ENV_B: state_ff <= S_SQRT_INIT;
            S_SQRT_INIT: begin
               cnt_ff   <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_CHECK;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_CHECK: begin
               sel_ff   <= 1'b0;
               state_ff <= status.take_log ? S_LOG_INIT : S_TARGET;
            end
            S_LOG_INIT: begin
               cnt_ff   <= '0;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (cnt_ff == 5'(NORM_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_LOG_MANT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_LOG_MANT: state_ff <= S_LOG_SQ;
            S_LOG_SQ: begin
               if (cnt_ff == 5'(LOG_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= sel_ff ? S_SCALE : S_LOG_SAVE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_LOG_SAVE: begin
               sel_ff   <= 1'b1;
               state_ff <= S_LOG_INIT;
            end
            S_SCALE: state_ff <= S_EXP_INIT;
            S_EXP_INIT: begin
               cnt_ff   <= '0;
               state_ff <= S_EXP;
            end
            S_EXP: begin
               if (cnt_ff == 5'(EXP_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_TARGET;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_TARGET: state_ff <= S_GAIN;
            S_GAIN: begin
               chan_ff  <= 1'b0;
               state_ff <= S_OUT_MAG;
            end
            S_OUT_MAG: state_ff <= S_OUT_VOL;
            S_OUT_VOL: state_ff <= S_OUT_SUM;
            S_OUT_SUM: begin
               if (chan_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  chan_ff  <= 1'b1;
                  state_ff <= S_OUT_MAG;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  req_stall_ff <= 1'b0;
                  chan_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: design/spc_datapath.sv
// Datapath: envelope, square root, log2, exp2, gain and output units on one multiplier.
module spc_datapath
   import spc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  spc_cfg_type    cfg,
   input  spc_cmd_type    cmd,
   input  spc_req_type    req_data,
   output spc_status_type status,
   output spc_rsp_type    rsp_data
);

   localparam int SB = SAMPLE_BITS;
   localparam spc_root_tab_type ExpRoot = spc_exp_table();
   localparam logic signed [SB+1:0] SatHi = (SB+2)'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic signed [SB+1:0] SatLo = -SatHi - (SB+2)'(1);
   localparam logic [48:0] MagClamp = 49'(64'd1 << SB);

   // Registers and their next values.
   logic signed [SB-1:0] samp_l_ff, samp_l_in, samp_r_ff, samp_r_in;
   logic signed [SB-1:0] prior_l_ff, prior_l_in, prior_r_ff, prior_r_in;
   logic [31:0] mag_ff, mag_in;
   logic [56:0] acc_ff, acc_in;
   logic [31:0] env_ff, env_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] root_ff, root_in;
   logic [31:0] norm_ff, norm_in;
   logic [4:0]  pos_ff, pos_in;
   logic [30:0] mant_ff, mant_in;
   logic [15:0] frac_ff, frac_in;
   logic [20:0] loga_ff, loga_in;
   logic [21:0] q_ff, q_in;
   logic [15:0] earg_ff, earg_in;
   logic [30:0] r30_ff, r30_in;
   logic [24:0] tgt_ff, tgt_in;
   logic [24:0] gain_ff, gain_in;
   logic [32:0] m1_ff, m1_in;
   logic [SB:0] mout_ff, mout_in;
   logic signed [SB-1:0] res_l_ff, res_l_in, res_r_ff, res_r_in;
   spc_rsp_type rsp_ff, rsp_in;

   // Shared multiplier.
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] prod;

   // Helpers.
   logic [31:0] level;
   logic [31:0] thr32;
   logic [31:0] thl;
   logic        compress;
   logic [16:0] slope;
   logic [20:0] log_diff;
   logic [SB-1:0] abs_l_req, abs_r_req, abs_max;
   logic [SB-1:0] abs_chan;
   logic signed [SB-1:0] samp_chan, prior_chan;
   logic [63:0] bit_val;
   logic [63:0] trial;
   logic [31:0] sq_top;
   logic [64:0] rnd;
   logic [5:0]  exp_int;
   logic [6:0]  shr;
   logic [30:0] r_shr;
   logic [32:0] r_shl;
   logic [33:0] g_new;
   logic [48:0] m2;
   logic signed [SB+1:0] mv, pv, sv;

   function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] s);
      logic [SB-1:0] u;
      u = s;
      return s[SB-1] ? (~u + 1'b1) : u;
   endfunction

   assign level    = root_ff[31:0];
   assign thr32    = {1'b0, cfg.threshold, 7'b0};
   assign thl      = (thr32 == '0) ? 32'd1 : thr32;
   assign compress = cfg.ratio_slope < SLOPE_UNITY;
   assign slope    = compress ? (SLOPE_UNITY - cfg.ratio_slope)
                              : (cfg.ratio_slope - SLOPE_UNITY);
   assign log_diff = loga_ff - {pos_ff, frac_ff};
   assign status.take_log = (level > thr32) && (cfg.ratio_slope != SLOPE_UNITY);

   assign abs_l_req  = mag_of(req_data.left_in);
   assign abs_r_req  = mag_of(req_data.right_in);
   assign abs_max    = (abs_l_req > abs_r_req) ? abs_l_req : abs_r_req;
   assign samp_chan  = cmd.chan ? samp_r_ff : samp_l_ff;
   assign prior_chan = cmd.chan ? prior_r_ff : prior_l_ff;
   assign abs_chan   = mag_of(samp_chan);

   assign rsp_data = rsp_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_ENV_A: begin
            mul_a = 33'(mag_ff);
            mul_b = 32'(cfg.env_coef);
         end
         OP_ENV_B: begin
            mul_a = 33'(25'h1000000 - 25'(cfg.env_coef));
            mul_b = env_ff;
         end
         OP_LOG_SQ: begin
            mul_a = 33'(mant_ff);
            mul_b = 32'(mant_ff);
         end
         OP_SCALE: begin
            mul_a = 33'(log_diff);
            mul_b = 32'(slope);
         end
         OP_EXP_STEP: begin
            mul_a = 33'(r30_ff);
            mul_b = ExpRoot[cmd.idx[3:0]];
         end
         OP_GAIN: begin
            mul_a = 33'(gain_ff);
            mul_b = (gain_ff > tgt_ff) ? 32'(cfg.attack_coef) : cfg.release_mult;
         end
         OP_OUT_MAG: begin
            mul_a = 33'(abs_chan);
            mul_b = 32'(gain_ff);
         end
         OP_OUT_VOL: begin
            mul_a = m1_ff;
            mul_b = cfg.volume;
         end
         default: ;
      endcase
   end

   assign prod = 65'(mul_a) * 65'(mul_b);

   // Next-value logic for every operation.
   always_comb begin
      samp_l_in  = samp_l_ff;
      samp_r_in  = samp_r_ff;
      prior_l_in = prior_l_ff;
      prior_r_in = prior_r_ff;
      mag_in     = mag_ff;
      acc_in     = acc_ff;
      env_in     = env_ff;
      x_in       = x_ff;
      root_in    = root_ff;
      norm_in    = norm_ff;
      pos_in     = pos_ff;
      mant_in    = mant_ff;
      frac_in    = frac_ff;
      loga_in    = loga_ff;
      q_in       = q_ff;
      earg_in    = earg_ff;
      r30_in     = r30_ff;
      tgt_in     = tgt_ff;
      gain_in    = gain_ff;
      m1_in      = m1_ff;
      mout_in    = mout_ff;
      res_l_in   = res_l_ff;
      res_r_in   = res_r_ff;
      rsp_in     = rsp_ff;

      bit_val = 64'h4000_0000_0000_0000 >> {cmd.idx, 1'b0};
      trial   = root_ff + bit_val;
      sq_top  = prod[61:30];
      rnd     = prod + 65'(64'd1 << 29);
      exp_int = q_ff[21:16];
      shr     = {1'b0, exp_int} + {6'b0, |q_ff[15:0]};
      r_shr   = r30_ff >> shr;
      r_shl   = {2'b0, r30_ff} << exp_int[0];
      g_new   = prod[57:24];
      m2      = prod[64:16];
      mv      = samp_chan[SB-1] ? -$signed({1'b0, mout_ff}) : $signed({1'b0, mout_ff});
      pv      = cfg.accumulate ? (SB+2)'(prior_chan) : '0;
      sv      = mv + pv;

      case (cmd.op)
         // Capture the pair and form the peak magnitude in Q1.31.
         OP_LOAD: begin
            samp_l_in  = req_data.left_in;
            samp_r_in  = req_data.right_in;
            prior_l_in = req_data.left_prior;
            prior_r_in = req_data.right_prior;
            mag_in     = 32'(abs_max) << (32 - SB);
         end
         // One-pole lowpass in two products.
         OP_ENV_A: acc_in = prod[56:0];
         OP_ENV_B: env_in = 32'((58'(acc_ff) + prod[57:0]) >> 24);
         // Bit-serial square root of the envelope scaled by 2^31.
         OP_SQRT_INIT: begin
            x_in    = {1'b0, env_ff, 31'b0};
            root_in = '0;
         end
         OP_SQRT_STEP: begin
            if (x_ff >= trial) begin
               x_in    = x_ff - trial;
               root_in = (root_ff >> 1) + bit_val;
            end else begin
               root_in = root_ff >> 1;
            end
         end
         // Normalize the log operand in halving steps.
         OP_LOG_INIT: begin
            norm_in = cmd.sel ? thl : level;
            pos_in  = 5'd31;
         end
         OP_NORM_STEP: begin
            case (cmd.idx)
               5'd0: if (norm_ff[31:16] == '0) begin
                  norm_in = norm_ff << 16;
                  pos_in  = pos_ff - 5'd16;
               end
               5'd1: if (norm_ff[31:24] == '0) begin
                  norm_in = norm_ff << 8;
                  pos_in  = pos_ff - 5'd8;
               end
               5'd2: if (norm_ff[31:28] == '0) begin
                  norm_in = norm_ff << 4;
                  pos_in  = pos_ff - 5'd4;
               end
               5'd3: if (norm_ff[31:30] == '0) begin
                  norm_in = norm_ff << 2;
                  pos_in  = pos_ff - 5'd2;
               end
               5'd4: if (!norm_ff[31]) begin
                  norm_in = norm_ff << 1;
                  pos_in  = pos_ff - 5'd1;
               end
               default: ;
            endcase
         end
         OP_LOG_MANT: begin
            mant_in = norm_ff[31:1];
            frac_in = '0;
         end
         // One fraction bit of log2 per squaring.
         OP_LOG_SQ: begin
            frac_in = {frac_ff[14:0], sq_top[31]};
            mant_in = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
         end
         OP_LOG_SAVE: loga_in = {pos_ff, frac_ff};
         OP_SCALE:    q_in = prod[37:16];
         // Fractional power of two from the root table.
         OP_EXP_INIT: begin
            earg_in = compress ? (16'd0 - q_ff[15:0]) : q_ff[15:0];
            r30_in  = 31'h4000_0000;
         end
         OP_EXP_STEP: begin
            if (earg_ff[4'd15 - cmd.idx[3:0]]) begin
               r30_in = rnd[60:30];
            end
         end
         // Target gain in Q1.24.
         OP_TARGET: begin
            if (!status.take_log) begin
               tgt_in = GAIN_UNITY;
            end else if (compress) begin
               tgt_in = r_shr[30:6];
            end else if (exp_int >= 6'd2 || 27'(r_shl[32:6]) > 27'(GAIN_MAX)) begin
               tgt_in = GAIN_MAX;
            end else begin
               tgt_in = r_shl[30:6];
            end
         end
         // Attack or release step, never past the target.
         OP_GAIN: begin
            if (gain_ff > tgt_ff) begin
               gain_in = (g_new > 34'(tgt_ff)) ? g_new[24:0] : tgt_ff;
            end else begin
               gain_in = (g_new < 34'(tgt_ff)) ? g_new[24:0] : tgt_ff;
            end
         end
         // Output magnitude, volume, sign, accumulate and saturate.
         OP_OUT_MAG: m1_in = prod[56:24];
         OP_OUT_VOL: mout_in = (m2 > MagClamp) ? MagClamp[SB:0] : m2[SB:0];
         OP_OUT_SUM: begin
            if (sv > SatHi) begin
               sv = SatHi;
            end else if (sv < SatLo) begin
               sv = SatLo;
            end
            if (cmd.chan) begin
               res_r_in = sv[SB-1:0];
            end else begin
               res_l_in = sv[SB-1:0];
            end
         end
         OP_EMIT: begin
            rsp_in.left_out  = res_l_ff;
            rsp_in.right_out = res_r_ff;
         end
         default: ;
      endcase
   end

   // Filter state: envelope cleared and gain set to unity at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff  <= '0;
         gain_ff <= GAIN_UNITY;
      end else begin
         env_ff  <= env_in;
         gain_ff <= gain_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      samp_l_ff  <= samp_l_in;
      samp_r_ff  <= samp_r_in;
      prior_l_ff <= prior_l_in;
      prior_r_ff <= prior_r_in;
      mag_ff     <= mag_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      root_ff    <= root_in;
      norm_ff    <= norm_in;
      pos_ff     <= pos_in;
      mant_ff    <= mant_in;
      frac_ff    <= frac_in;
      loga_ff    <= loga_in;
      q_ff       <= q_in;
      earg_ff    <= earg_in;
      r30_ff     <= r30_in;
      tgt_ff     <= tgt_in;
      m1_ff      <= m1_in;
      mout_ff    <= mout_in;
      res_l_ff   <= res_l_in;
      res_r_ff   <= res_r_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: bench/stereo_peak_compressor_tb.sv
// Self-checking testbench for the stereo peak compressor with a built-in gain predictor.
module stereo_peak_compressor_tb
   import spc_pkg::*;
();

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   spc_req_type              req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   spc_rsp_type              rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   stereo_peak_compressor u_top (.*);

   always #1 clock = ~clock;

   // Predictor copy of the registers and the loop state.
   spc_cfg_type cfg;
   logic [63:0] env_level;
   logic [63:0] gain_now;

   spc_rsp_type expected_pairs[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // Integer square root by the bit-pair method.
   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Base-two logarithm in Q.16, fraction by repeated squaring.
   function automatic logic [63:0] log2_q16(logic [63:0] x);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      p = 0;
      frac = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(p) << 16) | frac;
   endfunction

   // Fractional power of two in Q1.30 from a chain of square roots of two.
   function automatic logic [63:0] pow2_frac(logic [63:0] f);
      logic [63:0] r;
      logic [63:0] c;
      r = 64'd1 << 30;
      c = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) begin
         c = int_sqrt(c << 30);
         if ((f >> (16 - k)) & 1) r = (r * c + (64'd1 << 29)) >> 30;
      end
      return r;
   endfunction

   // Gain that the level asks for, in Q1.24.
   function automatic logic [63:0] gain_target(logic [63:0] level);
      logic [63:0] thr;
      logic [63:0] d;
      logic [63:0] sl;
      logic [63:0] q;
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] slope;
      thr = 64'(cfg.threshold) << 7;
      slope = 64'(cfg.ratio_slope);
      if (level <= thr) return 64'(GAIN_UNITY);
      d = log2_q16(level) - log2_q16(thr != 0 ? thr : 64'd1);
      if (slope == 64'(SLOPE_UNITY)) return 64'(GAIN_UNITY);
      sl = (slope > 64'(SLOPE_UNITY)) ? slope - 65536 : 65536 - slope;
      q = (d * sl) >> 16;
      n = q >> 16;
      f = q & 64'hFFFF;
      if (slope < 64'(SLOPE_UNITY)) begin
         if (f == 0) r = (n >= 64) ? 0 : ((64'd1 << 30) >> n);
         else r = (n + 1 >= 64) ? 0 : (pow2_frac(65536 - f) >> (n + 1));
         return r >> 6;
      end
      if (n >= 2) return 64'(GAIN_MAX);
      r = (pow2_frac(f) << n) >> 6;
      return (r > 64'(GAIN_MAX)) ? 64'(GAIN_MAX) : r;
   endfunction

   // Scale one sample by gain and volume, add the prior and saturate.
   function automatic logic [SAMPLE_BITS-1:0] scaled_sample(
      logic signed [SAMPLE_BITS-1:0] s, logic signed [SAMPLE_BITS-1:0] prior);
      logic [63:0]        m;
      longint             v;
      m = (s < 0) ? 64'(-longint'(s)) : 64'(longint'(s));
      m = (m * gain_now) >> 24;
      m = m * 64'(cfg.volume >> 16) + ((m * 64'(cfg.volume[15:0])) >> 16);
      if (m > (64'd1 << SAMPLE_BITS)) m = 64'd1 << SAMPLE_BITS;
      v = (s < 0) ? -longint'(m) : longint'(m);
      if (cfg.accumulate) v = v + longint'(prior);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Advance the detector and gain loop by one pair and store the expected outputs.
   function automatic void predict_pair(spc_req_type rq);
      logic [63:0] al;
      logic [63:0] ar;
      logic [63:0] mag;
      logic [63:0] level;
      logic [63:0] tgt;
      logic [63:0] g;
      spc_rsp_type rs;
      al = (rq.left_in < 0) ? 64'(-longint'(rq.left_in)) : 64'(longint'(rq.left_in));
      ar = (rq.right_in < 0) ? 64'(-longint'(rq.right_in)) : 64'(longint'(rq.right_in));
      mag = ((al > ar) ? al : ar) << (32 - SAMPLE_BITS);
      env_level = ((64'(cfg.env_coef) * mag + (64'(GAIN_UNITY) - 64'(cfg.env_coef))
                   * env_level) >> 24) & 64'hFFFFFFFF;
      level = int_sqrt(env_level << 31);
      tgt = gain_target(level);
      if (gain_now > tgt) begin
         g = (gain_now * 64'(cfg.attack_coef)) >> 24;
         gain_now = (g > tgt) ? g : tgt;
      end else begin
         g = (gain_now * 64'(cfg.release_mult)) >> 24;
         gain_now = (g < tgt) ? g : tgt;
      end
      rs.left_out = scaled_sample(rq.left_in, rq.left_prior);
      rs.right_out = scaled_sample(rq.right_in, rq.right_prior);
      expected_pairs.push_back(rs);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Receiver: random stall and comparison of each result beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 0);
         end else begin
            if (rsp_data.left_out !== expected_pairs[0].left_out)
               report_mismatch("left_out", rsp_data.left_out, expected_pairs[0].left_out);
            if (rsp_data.right_out !== expected_pairs[0].right_out)
               report_mismatch("right_out", rsp_data.right_out, expected_pairs[0].right_out);
            void'(expected_pairs.pop_front());
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Send one pair, with an optional random idle gap first; valid stays up for the next call.
   task automatic send_pair(input spc_req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pair(rq);
   endtask

   // Drop valid, wait for every result and let the block settle before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_THRESHOLD:  cfg.threshold = value[23:0];
         REG_RATIO:      cfg.ratio_slope = value[16:0];
         REG_ATTACK:     cfg.attack_coef = value[23:0];
         REG_RELEASE:    cfg.release_mult = value;
         REG_ENV_COEF:   cfg.env_coef = value[23:0];
         REG_VOLUME:     cfg.volume = value;
         REG_ACCUMULATE: cfg.accumulate = value[0];
         default: ;
      endcase
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'(int'($urandom_range(2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic spc_req_type rand_pair();
      spc_req_type rq;
      rq.left_in = rand_sample();
      rq.right_in = ($urandom_range(3) == 0) ? rand_sample() : rq.left_in;
      rq.left_prior = rand_sample();
      rq.right_prior = rand_sample();
      return rq;
   endfunction

   // Load one of several register settings, extremes included.
   task automatic load_setting(input int n);
      drain();
      case (n % 5)
         0: begin
            write_reg(REG_THRESHOLD, 32'd0);
            write_reg(REG_RATIO, 32'd0);
            write_reg(REG_ATTACK, 32'd0);
            write_reg(REG_RELEASE, 32'hFFFFFFFF);
            write_reg(REG_ENV_COEF, 32'hFFFFFF);
            write_reg(REG_VOLUME, 32'hFFFFFFFF);
            write_reg(REG_ACCUMULATE, 32'd1);
         end
         1: begin
            write_reg(REG_THRESHOLD, 32'hFFFFFF);
            write_reg(REG_RATIO, 32'd65536);
            write_reg(REG_ATTACK, 32'hFFFFFF);
            write_reg(REG_RELEASE, 32'd16777216);
            write_reg(REG_ENV_COEF, 32'd0);
            write_reg(REG_VOLUME, 32'd0);
            write_reg(REG_ACCUMULATE, 32'd0);
         end
         2: begin
            write_reg(REG_THRESHOLD, $urandom_range(24'h200000, 24'h10000));
            write_reg(REG_RATIO, $urandom_range(70000, 131071));
            write_reg(REG_ATTACK, $urandom_range(24'hFFFFFF, 24'hF00000));
            write_reg(REG_RELEASE, $urandom_range(32'h1100000, 32'h1000000));
            write_reg(REG_ENV_COEF, $urandom_range(24'hFFFFFF, 24'h100000));
            write_reg(REG_VOLUME, $urandom_range(32'h40000, 32'h8000));
            write_reg(REG_ACCUMULATE, 32'($urandom_range(1)));
         end
         default: begin
            write_reg(REG_THRESHOLD, $urandom_range(24'h400000, 24'h1000));
            write_reg(REG_RATIO, $urandom_range(65535, 0));
            write_reg(REG_ATTACK, $urandom_range(24'hFFFFFF, 24'hC00000));
            write_reg(REG_RELEASE, $urandom_range(32'h1400000, 32'h1000000));
            write_reg(REG_ENV_COEF, $urandom);
            write_reg(REG_VOLUME, $urandom);
            write_reg(REG_ACCUMULATE, 32'($urandom_range(1)));
         end
      endcase
   endtask

   // Directed pairs: full-scale, zero, sign mix, under reset defaults and extremes.
   task automatic test_directed();
      spc_req_type rq;
      logic [23:0] edges[6] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001,
                                24'hFFFFFF, 24'h555555};
      for (int i = 0; i < 12; i++) begin
         rq.left_in = edges[i % 6];
         rq.right_in = edges[(i + 1) % 6];
         rq.left_prior = edges[(i + 2) % 6];
         rq.right_prior = edges[(i + 3) % 6];
         send_pair(rq);
      end
      // Zero threshold with expansion, saturating gain and full volume.
      load_setting(0);
      write_reg(REG_RATIO, 32'h1FFFF);
      for (int i = 0; i < 6; i++) begin
         rq = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000};
         send_pair(rq);
      end
      // Pause until every result is back.
      drain();
      load_setting(1);
      for (int i = 0; i < 6; i++) send_pair(rand_pair());
   endtask

   // Random pairs across many settings and three idling patterns.
   task automatic test_random();
      for (int phase = 0; phase < 12; phase++) begin
         case (phase / 4)
            0: begin send_idle_pct = 10; recv_stall_pct = 71; end
            1: begin send_idle_pct = 71; recv_stall_pct = 10; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         load_setting(phase + 2);
         for (int i = 0; i < 140; i++) send_pair(rand_pair());
      end
   endtask

   initial begin
      cfg = '{THRESHOLD_RESET, RATIO_RESET, ATTACK_RESET, RELEASE_RESET,
              ENV_COEF_RESET, VOLUME_RESET, 1'b0};
      env_level = 0;
      gain_now = 64'(GAIN_UNITY);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      drain();
      if (error_count == 0) $display("stereo_peak_compressor_tb passed");
      else $display("stereo_peak_compressor_tb failed");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("stereo_peak_compressor_tb failed");
      $finish;
   end

endmodule
